FILE: rtl/dqrs_pkg.sv
// Package: shared types and codes for the ring-store double-ended queue.
package dqrs_pkg;

  localparam int unsigned ELEM_BITS = 32;
  localparam int unsigned VALUE_BITS = 32;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_BACK  = 2'd1,
    ACT_DEL_FRONT = 2'd2,
    ACT_DEL_BACK  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } sts_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } fsm_t;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_PUSH_FRONT = 3'd1,
    CELL_PUT_BACK   = 3'd2,
    CELL_PULL_FRONT = 3'd3,
    CELL_ROTATE     = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      tail;
  } cell_ctrl_t;

endpackage

FILE: rtl/dqrs_cell.sv
// One storage cell of the queue chain: holds a word and trades it with its neighbours.
module dqrs_cell #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                   clk,
  input  dqrs_pkg::cell_ctrl_t   ctrl,
  input  logic [WORD_BITS-1:0]   left_d,
  input  logic [WORD_BITS-1:0]   right_d,
  input  logic [WORD_BITS-1:0]   head_d,
  input  logic [WORD_BITS-1:0]   wr_d,
  output logic [WORD_BITS-1:0]   q
);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (ctrl.cmd)
      dqrs_pkg::CELL_PUSH_FRONT: word_nxt = left_d;
      dqrs_pkg::CELL_PUT_BACK: begin
        if (ctrl.tail) begin
          word_nxt = wr_d;
        end
      end
      dqrs_pkg::CELL_PULL_FRONT: word_nxt = right_d;
      dqrs_pkg::CELL_ROTATE:     word_nxt = ctrl.tail ? head_d : right_d;
      default:                   word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

FILE: rtl/deque_ring_store_core.sv
// Top level: bounded double-ended queue of words held in a chain of cells, with listing output.
// Each action is taken and is followed by its listing: one result per stored entry, front
// to back, or a single empty result. The listing rate is set by the cell chain, which
// rotates the occupied entries by one place a cycle, when the output side does not stall,
// so that each entry in turn reaches the head cell. The next action is accepted as soon as
// the final result of a listing sits in the output register. Entries are kept with the head
// of the queue in cell zero; inserts and deletes at the front shift the whole chain.
module deque_ring_store_core #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [33:2] element, [39:34] zero
  output logic [0:0]  out_tuser,  // [0] has_element
  output logic        out_tlast
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned EB    = dqrs_pkg::ELEM_BITS;

  dqrs_pkg::fsm_t       state_r, state_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  dqrs_pkg::sts_t       status_r, status_nxt;
  dqrs_pkg::cell_cmd_t  cmd;

  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [EB-1:0]        elem_r;
  logic                 has_r;
  logic                 last_r;
  dqrs_pkg::sts_t       osts_r;

  logic                 in_acc;
  logic                 advance;
  logic                 last_item;
  logic                 full;
  logic                 empty;
  dqrs_pkg::act_t       act;

  logic [WORD_BITS-1:0] wr_word;
  logic [EB-1:0]        head_elem;
  logic [WORD_BITS-1:0] cell_q [CAPACITY];
  dqrs_pkg::cell_ctrl_t cell_ctrl [CAPACITY];

  assign act       = dqrs_pkg::act_t'(in_tuser);
  assign in_tready = (state_r == dqrs_pkg::FSM_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (occ_r == OCC_W'(CAPACITY));
  assign empty     = (occ_r == '0);
  assign advance   = (state_r == dqrs_pkg::FSM_LIST) && (!out_tvalid_r || out_tready);
  assign last_item = empty || ((OCC_W'(cnt_r) + OCC_W'(1)) == occ_r);

  generate
    if (WORD_BITS >= dqrs_pkg::VALUE_BITS) begin : g_wide
      assign wr_word   = WORD_BITS'(in_tdata);
      assign head_elem = cell_q[0][EB-1:0];
    end else begin : g_narrow
      assign wr_word   = in_tdata[WORD_BITS-1:0];
      assign head_elem = EB'(cell_q[0]);
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    cmd        = dqrs_pkg::CELL_HOLD;
    unique case (state_r)
      dqrs_pkg::FSM_IDLE: begin
        if (in_acc) begin
          state_nxt  = dqrs_pkg::FSM_LIST;
          cnt_nxt    = '0;
          status_nxt = dqrs_pkg::STS_DONE;
          case (act)
            dqrs_pkg::ACT_INS_FRONT: begin
              if (full) begin
                status_nxt = dqrs_pkg::STS_FULL;
              end else begin
                cmd     = dqrs_pkg::CELL_PUSH_FRONT;
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            dqrs_pkg::ACT_INS_BACK: begin
              if (full) begin
                status_nxt = dqrs_pkg::STS_FULL;
              end else begin
                cmd     = dqrs_pkg::CELL_PUT_BACK;
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            dqrs_pkg::ACT_DEL_FRONT: begin
              if (empty) begin
                status_nxt = dqrs_pkg::STS_EMPTY;
              end else begin
                cmd     = dqrs_pkg::CELL_PULL_FRONT;
                occ_nxt = occ_r - OCC_W'(1);
              end
            end
            default: begin
              if (empty) begin
                status_nxt = dqrs_pkg::STS_EMPTY;
              end else begin
                occ_nxt = occ_r - OCC_W'(1);
              end
            end
          endcase
        end
      end
      dqrs_pkg::FSM_LIST: begin
        if (advance) begin
          if (!empty) begin
            cmd = dqrs_pkg::CELL_ROTATE;
          end
          if (last_item) begin
            state_nxt = dqrs_pkg::FSM_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = dqrs_pkg::FSM_IDLE;
    endcase
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_w;
      logic [WORD_BITS-1:0] right_w;

      always_comb begin
        cell_ctrl[i].cmd  = cmd;
        cell_ctrl[i].tail = (cmd == dqrs_pkg::CELL_PUT_BACK) ? (occ_r == OCC_W'(i))
                                                              : (occ_r == OCC_W'(i + 1));
      end

      if (i == 0) begin : g_first
        assign left_w = wr_word;
      end else begin : g_mid
        assign left_w = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
        assign right_w = cell_q[0];
      end else begin : g_inner
        assign right_w = cell_q[i+1];
      end

      dqrs_cell #(
        .WORD_BITS (WORD_BITS)
      ) u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl[i]),
        .left_d  (left_w),
        .right_d (right_w),
        .head_d  (cell_q[0]),
        .wr_d    (wr_word),
        .q       (cell_q[i])
      );
    end
  endgenerate

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (advance) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dqrs_pkg::FSM_IDLE;
      occ_r        <= '0;
      cnt_r        <= '0;
      status_r     <= dqrs_pkg::STS_DONE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      cnt_r        <= cnt_nxt;
      status_r     <= status_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      elem_r <= empty ? '0 : head_elem;
      has_r  <= !empty;
      last_r <= last_item;
      osts_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, elem_r, osts_r};
  assign out_tuser  = has_r;
  assign out_tlast  = last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_list_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dqrs_pkg::FSM_LIST) |-> ((OCC_W'(cnt_r) < occ_r) || (empty && cnt_r == '0)))
    else $error("listing counter outside occupied range");

  a_accept_lists: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == dqrs_pkg::FSM_LIST))
    else $error("accepted action not followed by listing");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full && (act == dqrs_pkg::ACT_INS_FRONT || act == dqrs_pkg::ACT_INS_BACK))
      |=> (status_r == dqrs_pkg::STS_FULL && $stable(occ_r)))
    else $error("insert into full store not rejected");

  a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && empty && (act == dqrs_pkg::ACT_DEL_FRONT || act == dqrs_pkg::ACT_DEL_BACK))
      |=> (status_r == dqrs_pkg::STS_EMPTY && occ_r == '0))
    else $error("delete from empty store not rejected");

endmodule
